[hdl/assert_macros.svh]
// Assertion macros used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

// Next-cycle implication that also runs through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: %m");

`endif

[hdl/gqspe_pkg.sv]
package gqspe_pkg;

   // parameter defaults
   localparam int MAX_VARS_DEF    = 32;
   localparam int FIXED_COUNT_DEF = 4;
   localparam int EQ_BITS_DEF     = 32;

   // field and register widths
   localparam int VAR_W      = 6;   // variable numbers, up to the largest MAX_VARS
   localparam int IDX_W      = 9;
   localparam int WORD_W     = 32;
   localparam int NUM_VARS_W = 6;
   localparam int FIX_VAL_W  = 4;
   localparam int FIX_IW     = $clog2(FIX_VAL_W);
   localparam int CSR_AW     = 3;
   localparam int CSR_DW     = 32;
   localparam logic [NUM_VARS_W-1:0] NUM_VARS_RST = 6'd32;

   // op queue depth between front and back
   localparam int Q_DEPTH = 4;

   // register map, word index = paddr[2]
   typedef enum logic {
      REG_NUM_VARS     = 1'b0,
      REG_FIXED_VALUES = 1'b1
   } reg_idx_type;

   // stream position
   typedef enum logic [1:0] {
      PH_CONST = 2'd0,
      PH_LIN   = 2'd1,
      PH_QUAD  = 2'd2
   } phase_type;

   // what the back end does with one coefficient
   typedef enum logic [2:0] {
      OP_NOP    = 3'd0,
      OP_SET0   = 3'd1,
      OP_XOR0   = 3'd2,
      OP_SETLIN = 3'd3,
      OP_XORLIN = 3'd4,
      OP_EMIT   = 3'd5
   } op_kind_type;

   typedef struct packed {
      op_kind_type        kind;
      logic [VAR_W-1:0]   addr;       // linear accumulator slot
      logic [IDX_W-1:0]   idx;        // output index for a kept quadratic term
      logic               last_coef;  // final coefficient, drain follows
      logic [VAR_W-1:0]   nn;         // kept variable count
   } op_type;

   typedef enum logic [1:0] {
      BK_RUN       = 2'd0,
      BK_DRAIN_RD  = 2'd1,
      BK_DRAIN_PUT = 2'd2
   } back_state_type;

endpackage

[hdl/gqspe_ram.sv]
module gqspe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 28,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read returns old data on collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/gqspe_fifo.sv]
module gqspe_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW:0]      wr_ptr_ff, wr_ptr_in;
   logic [PW:0]      rd_ptr_ff, rd_ptr_in;

   // pointers carry one wrap bit
   assign empty = (wr_ptr_ff == rd_ptr_ff);
   assign full  = (wr_ptr_ff[PW] != rd_ptr_ff[PW]) && (wr_ptr_ff[PW-1:0] == rd_ptr_ff[PW-1:0]);
   assign pop_data = mem_ff[rd_ptr_ff[PW-1:0]];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push && !full) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop && !empty) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff[PW-1:0]] <= push_data;
      end
   end

endmodule

[hdl/gqspe_front.sv]
module gqspe_front #(
   parameter int MAX_VARS    = gqspe_pkg::MAX_VARS_DEF,
   parameter int FIXED_COUNT = gqspe_pkg::FIXED_COUNT_DEF,
   parameter int EQ_BITS     = gqspe_pkg::EQ_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // register port
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gqspe_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [gqspe_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [gqspe_pkg::CSR_DW-1:0]    csr_prdata,
   // coefficient stream
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gqspe_pkg::WORD_W-1:0]    req_coef_word,
   // op queue
   output logic                            q_push,
   output gqspe_pkg::op_type               q_op,
   output logic [((EQ_BITS < gqspe_pkg::WORD_W) ? EQ_BITS : gqspe_pkg::WORD_W)-1:0] q_word,
   input  logic                            q_full
);

   localparam int WW         = (EQ_BITS < gqspe_pkg::WORD_W) ? EQ_BITS : gqspe_pkg::WORD_W;
   localparam int VW         = $clog2(MAX_VARS + 1);
   localparam int VAR_W      = gqspe_pkg::VAR_W;
   localparam int IDX_W      = gqspe_pkg::IDX_W;
   localparam int NUM_VARS_W = gqspe_pkg::NUM_VARS_W;
   localparam int FIX_VAL_W  = gqspe_pkg::FIX_VAL_W;
   localparam int FIX_IW     = gqspe_pkg::FIX_IW;
   localparam int CSR_DW     = gqspe_pkg::CSR_DW;
   localparam logic [VW-1:0] FC    = VW'(FIXED_COUNT);
   localparam logic [VW-1:0] N_MAX = VW'(MAX_VARS);
   localparam logic [VW-1:0] N_MIN = VW'(FIXED_COUNT + 1);
   localparam logic [NUM_VARS_W-1:0] NV_MAX = NUM_VARS_W'(MAX_VARS);
   localparam logic [NUM_VARS_W-1:0] NV_MIN = NUM_VARS_W'(FIXED_COUNT + 1);
   localparam logic [FIX_VAL_W-1:0] FIX_MASK =
      (FIXED_COUNT >= FIX_VAL_W) ? {FIX_VAL_W{1'b1}} : FIX_VAL_W'((1 << FIXED_COUNT) - 1);

   logic [NUM_VARS_W-1:0]  num_vars_ff, num_vars_in;
   logic [FIX_VAL_W-1:0]   fixed_ff, fixed_in;
   gqspe_pkg::phase_type   phase_ff, phase_in;
   logic [VW-1:0]          row_ff, row_in;
   logic [VW-1:0]          col_ff, col_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   logic                   cfg_wr;
   gqspe_pkg::reg_idx_type cfg_idx;
   logic [VW-1:0]          n_eff;
   logic [VW-1:0]          nn;
   logic [IDX_W-1:0]       first_quad;
   logic                   fix_row;
   logic                   fix_col;

   function automatic logic fix_bit(input logic [VW-1:0] k, input logic [FIX_VAL_W-1:0] vals);
      logic r;
      r = 1'b0;
      if ((k < FC) && (k < VW'(FIX_VAL_W))) begin
         r = vals[k[FIX_IW-1:0]];
      end
      return r;
   endfunction

   // register access
   assign cfg_wr  = csr_psel && csr_penable && csr_pwrite;
   assign cfg_idx = gqspe_pkg::reg_idx_type'(csr_paddr[2]);

   always_comb begin
      case (cfg_idx)
         gqspe_pkg::REG_NUM_VARS:     csr_prdata = CSR_DW'(num_vars_ff);
         gqspe_pkg::REG_FIXED_VALUES: csr_prdata = CSR_DW'(fixed_ff);
         default:                     csr_prdata = '0;
      endcase
   end

   // variable count clamped into the supported range
   always_comb begin
      if (num_vars_ff > NV_MAX) begin
         n_eff = N_MAX;
      end else if (num_vars_ff < NV_MIN) begin
         n_eff = N_MIN;
      end else begin
         n_eff = VW'(num_vars_ff);
      end
   end

   assign nn         = n_eff - FC;
   assign first_quad = IDX_W'(nn) + 1'b1;
   assign fix_row    = fix_bit(row_ff, fixed_ff);
   assign fix_col    = fix_bit(col_ff, fixed_ff);

   // intake
   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;
   assign q_word    = req_coef_word[WW-1:0];

   // classify the coefficient and step the monomial counters
   always_comb begin
      num_vars_in  = num_vars_ff;
      fixed_in     = fixed_ff;
      phase_in     = phase_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      idx_in       = idx_ff;
      q_op         = '0;
      q_op.kind    = gqspe_pkg::OP_NOP;
      q_op.nn      = VAR_W'(nn);
      if (cfg_wr) begin
         case (cfg_idx)
            gqspe_pkg::REG_NUM_VARS:     num_vars_in = csr_pwdata[NUM_VARS_W-1:0];
            gqspe_pkg::REG_FIXED_VALUES: fixed_in = csr_pwdata[FIX_VAL_W-1:0] & FIX_MASK;
            default: ;
         endcase
         // any write drops the system in progress
         phase_in = gqspe_pkg::PH_CONST;
         row_in   = '0;
         col_in   = '0;
         idx_in   = first_quad;
      end else if (q_push) begin
         case (phase_ff)
            gqspe_pkg::PH_LIN: begin
               if (row_ff < FC) begin
                  q_op.kind = fix_row ? gqspe_pkg::OP_XOR0 : gqspe_pkg::OP_NOP;
               end else begin
                  q_op.kind = gqspe_pkg::OP_SETLIN;
                  q_op.addr = VAR_W'(row_ff - FC);
               end
               row_in = row_ff + 1'b1;
               if ((row_ff + 1'b1) >= n_eff) begin
                  phase_in = gqspe_pkg::PH_QUAD;
                  row_in   = '0;
                  col_in   = VW'(1);
                  idx_in   = first_quad;
               end
            end
            gqspe_pkg::PH_QUAD: begin
               if (row_ff < FC) begin
                  if (col_ff < FC) begin
                     q_op.kind = (fix_row && fix_col) ? gqspe_pkg::OP_XOR0 : gqspe_pkg::OP_NOP;
                  end else if (fix_row) begin
                     q_op.kind = gqspe_pkg::OP_XORLIN;
                     q_op.addr = VAR_W'(col_ff - FC);
                  end
               end else begin
                  q_op.kind = gqspe_pkg::OP_EMIT;
                  q_op.idx  = idx_ff;
                  idx_in    = idx_ff + 1'b1;
               end
               col_in = col_ff + 1'b1;
               if ((col_ff + 1'b1) >= n_eff) begin
                  row_in = row_ff + 1'b1;
                  col_in = row_ff + 2'd2;
                  if ((row_ff + 2'd2) >= n_eff) begin
                     // final coefficient: drain follows, start over
                     q_op.last_coef = 1'b1;
                     phase_in       = gqspe_pkg::PH_CONST;
                     row_in         = '0;
                     col_in         = '0;
                     idx_in         = first_quad;
                  end
               end
            end
            default: begin
               // constant term, also the unused phase code
               q_op.kind = gqspe_pkg::OP_SET0;
               phase_in  = gqspe_pkg::PH_LIN;
               row_in    = '0;
               col_in    = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_vars_ff <= gqspe_pkg::NUM_VARS_RST;
         fixed_ff    <= '0;
         phase_ff    <= gqspe_pkg::PH_CONST;
         row_ff      <= '0;
         col_ff      <= '0;
         idx_ff      <= IDX_W'(MAX_VARS - FIXED_COUNT + 1);
      end else begin
         num_vars_ff <= num_vars_in;
         fixed_ff    <= fixed_in;
         phase_ff    <= phase_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         idx_ff      <= idx_in;
      end
   end

endmodule

[hdl/gqspe_back.sv]
module gqspe_back #(
   parameter int MAX_VARS    = gqspe_pkg::MAX_VARS_DEF,
   parameter int FIXED_COUNT = gqspe_pkg::FIXED_COUNT_DEF,
   parameter int EQ_BITS     = gqspe_pkg::EQ_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // op queue
   input  logic                            q_empty,
   output logic                            q_pop,
   input  gqspe_pkg::op_type               q_op,
   input  logic [((EQ_BITS < gqspe_pkg::WORD_W) ? EQ_BITS : gqspe_pkg::WORD_W)-1:0] q_word,
   // result stream
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gqspe_pkg::IDX_W-1:0]     rsp_out_index,
   output logic [gqspe_pkg::WORD_W-1:0]    rsp_out_word,
   output logic                            rsp_last
);

   localparam int WW        = (EQ_BITS < gqspe_pkg::WORD_W) ? EQ_BITS : gqspe_pkg::WORD_W;
   localparam int VW        = $clog2(MAX_VARS + 1);
   localparam int LIN_DEPTH = MAX_VARS - FIXED_COUNT;
   localparam int AW        = (LIN_DEPTH > 1) ? $clog2(LIN_DEPTH) : 1;
   localparam int IDX_W     = gqspe_pkg::IDX_W;
   localparam int WORD_W    = gqspe_pkg::WORD_W;

   gqspe_pkg::back_state_type state_ff, state_in;
   logic                      b_vld_ff, b_vld_in;
   gqspe_pkg::op_type         b_op_ff;
   logic [WW-1:0]             b_word_ff;
   logic [WW-1:0]             acc0_ff, acc0_in;
   logic                      fwd_vld_ff;
   logic [AW-1:0]             fwd_addr_ff;
   logic [WW-1:0]             fwd_data_ff;
   logic [VW-1:0]             k_ff, k_in;
   logic [VW-1:0]             nn_ff, nn_in;
   logic                      out_vld_ff, out_vld_in;
   logic [IDX_W-1:0]          out_idx_ff, out_idx_in;
   logic [WW-1:0]             out_word_ff, out_word_in;
   logic                      out_last_ff, out_last_in;

   logic                      slot_free;
   logic                      out_load;
   logic                      b_done;
   logic                      wr_en;
   logic [AW-1:0]             wr_addr;
   logic [WW-1:0]             wr_data;
   logic                      rd_en;
   logic [AW-1:0]             rd_addr;
   logic [WW-1:0]             rd_data;
   logic [AW-1:0]             b_addr;
   logic [WW-1:0]             lin_old;

   // linear accumulators 1..nn; every slot is set in the linear phase before use
   gqspe_ram #(
      .WIDTH (WW),
      .DEPTH (LIN_DEPTH),
      .AW    (AW)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign slot_free = !out_vld_ff || rsp_ready;
   assign b_addr    = b_op_ff.addr[AW-1:0];
   assign b_done    = b_vld_ff && ((b_op_ff.kind != gqspe_pkg::OP_EMIT) || slot_free);

   // take the next op once the held one retires, never past a drain request
   assign q_pop = !q_empty && (state_ff == gqspe_pkg::BK_RUN) &&
                  (!b_vld_ff || (b_done && !b_op_ff.last_coef));

   // read port: operand fetch on pop, sequential reads in the drain
   assign rd_en   = q_pop || (state_ff == gqspe_pkg::BK_DRAIN_RD);
   assign rd_addr = (state_ff == gqspe_pkg::BK_DRAIN_RD) ? AW'(k_ff - 1'b1)
                                                          : q_op.addr[AW-1:0];

   // bypass the write of the previous cycle
   assign lin_old = (fwd_vld_ff && (fwd_addr_ff == b_addr)) ? fwd_data_ff : rd_data;

   always_comb begin
      state_in    = state_ff;
      b_vld_in    = b_vld_ff;
      acc0_in     = acc0_ff;
      k_in        = k_ff;
      nn_in       = nn_ff;
      wr_en       = 1'b0;
      wr_addr     = b_addr;
      wr_data     = b_word_ff;
      out_load    = 1'b0;
      out_idx_in  = out_idx_ff;
      out_word_in = out_word_ff;
      out_last_in = out_last_ff;
      case (state_ff)
         gqspe_pkg::BK_RUN: begin
            if (b_done) begin
               case (b_op_ff.kind)
                  gqspe_pkg::OP_SET0:   acc0_in = b_word_ff;
                  gqspe_pkg::OP_XOR0:   acc0_in = acc0_ff ^ b_word_ff;
                  gqspe_pkg::OP_SETLIN: wr_en = 1'b1;
                  gqspe_pkg::OP_XORLIN: begin
                     wr_en   = 1'b1;
                     wr_data = lin_old ^ b_word_ff;
                  end
                  gqspe_pkg::OP_EMIT: begin
                     out_load    = 1'b1;
                     out_idx_in  = b_op_ff.idx;
                     out_word_in = b_word_ff;
                     out_last_in = 1'b0;
                  end
                  default: ;
               endcase
               if (b_op_ff.last_coef) begin
                  state_in = gqspe_pkg::BK_DRAIN_PUT;
                  k_in     = '0;
                  nn_in    = VW'(b_op_ff.nn);
               end
            end
            if (q_pop) begin
               b_vld_in = 1'b1;
            end else if (b_done) begin
               b_vld_in = 1'b0;
            end
         end
         gqspe_pkg::BK_DRAIN_RD: begin
            state_in = gqspe_pkg::BK_DRAIN_PUT;
         end
         gqspe_pkg::BK_DRAIN_PUT: begin
            if (slot_free) begin
               out_load    = 1'b1;
               out_idx_in  = IDX_W'(k_ff);
               out_word_in = (k_ff == '0) ? acc0_ff : rd_data;
               out_last_in = (k_ff == nn_ff);
               if (k_ff == nn_ff) begin
                  state_in = gqspe_pkg::BK_RUN;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = gqspe_pkg::BK_DRAIN_RD;
               end
            end
         end
         default: state_in = gqspe_pkg::BK_RUN;
      endcase
   end

   // output register
   always_comb begin
      out_vld_in = out_vld_ff;
      if (out_load) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= gqspe_pkg::BK_RUN;
         b_vld_ff   <= 1'b0;
         fwd_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
         k_ff       <= '0;
         nn_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         b_vld_ff   <= b_vld_in;
         fwd_vld_ff <= wr_en;
         out_vld_ff <= out_vld_in;
         k_ff       <= k_in;
         nn_ff      <= nn_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         b_op_ff   <= q_op;
         b_word_ff <= q_word;
      end
      acc0_ff     <= acc0_in;
      fwd_addr_ff <= wr_addr;
      fwd_data_ff <= wr_data;
      out_idx_ff  <= out_idx_in;
      out_word_ff <= out_word_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_out_index = out_idx_ff;
   assign rsp_out_word  = WORD_W'(out_word_ff);
   assign rsp_last      = out_last_ff;

endmodule

[hdl/gf2_quadratic_system_partial_eval_top.sv]
// Channel | Handshake           | Payload                                 | Role
// req     | req_valid/req_ready | req_coef_word                           | coefficient in
// rsp     | rsp_valid/rsp_ready | rsp_out_index, rsp_out_word, rsp_last   | reduced system out
// csr     | csr_psel/penable    | csr_paddr, csr_pwdata, csr_prdata       | num_vars 0x0, fixed 0x4
//
// One coefficient per cycle while the op queue has room; kept quadratic terms leave
// through the output register after they reach the back end.
// After the final coefficient the drain puts the constant, then does a read and a put
// per linear slot through the single read port of the accumulator RAM.
// Reset is synchronous; the accumulator RAM needs no clearing pass (slots are set before use).
// A stalled result holds the back end; the 4-entry queue then fills and drops req_ready.
module gf2_quadratic_system_partial_eval_top #(
   parameter int MAX_VARS    = gqspe_pkg::MAX_VARS_DEF,
   parameter int FIXED_COUNT = gqspe_pkg::FIXED_COUNT_DEF,
   parameter int EQ_BITS     = gqspe_pkg::EQ_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [gqspe_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [gqspe_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [gqspe_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                            csr_pready,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [gqspe_pkg::WORD_W-1:0]    req_coef_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [gqspe_pkg::IDX_W-1:0]     rsp_out_index,
   output logic [gqspe_pkg::WORD_W-1:0]    rsp_out_word,
   output logic                            rsp_last
);

   localparam int WW  = (EQ_BITS < gqspe_pkg::WORD_W) ? EQ_BITS : gqspe_pkg::WORD_W;
   localparam int QW  = $bits(gqspe_pkg::op_type) + WW;

   logic              f_push;
   gqspe_pkg::op_type f_op;
   logic [WW-1:0]     f_word;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;
   logic [QW-1:0]     q_data;
   gqspe_pkg::op_type q_op;
   logic [WW-1:0]     q_word;

   assign csr_pready = 1'b1;

   gqspe_front #(
      .MAX_VARS    (MAX_VARS),
      .FIXED_COUNT (FIXED_COUNT),
      .EQ_BITS     (EQ_BITS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_coef_word (req_coef_word),
      .q_push        (f_push),
      .q_op          (f_op),
      .q_word        (f_word),
      .q_full        (q_full)
   );

   gqspe_fifo #(
      .WIDTH (QW),
      .DEPTH (gqspe_pkg::Q_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (f_push),
      .push_data ({f_op, f_word}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_data),
      .empty     (q_empty)
   );

   assign {q_op, q_word} = q_data;

   gqspe_back #(
      .MAX_VARS    (MAX_VARS),
      .FIXED_COUNT (FIXED_COUNT),
      .EQ_BITS     (EQ_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .q_op          (q_op),
      .q_word        (q_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_index (rsp_out_index),
      .rsp_out_word  (rsp_out_word),
      .rsp_last      (rsp_last)
   );

endmodule

[hdl/gqspe_checker.sv]
`include "assert_macros.svh"

module gqspe_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [gqspe_pkg::WORD_W-1:0] req_coef_word,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [gqspe_pkg::IDX_W-1:0]  rsp_out_index,
   input logic [gqspe_pkg::WORD_W-1:0] rsp_out_word,
   input logic                         rsp_last
);

   // a stalled result keeps its transaction intact
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_index) && $stable(rsp_out_word) && $stable(rsp_last))

   // a stalled request keeps its transaction intact
   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_coef_word))

   // out of reset: queue not full, output register empty
   `ASSERT_NEXT_ALWAYS(a_reset_idle, clock, reset, req_ready && !rsp_valid)

   // the last item of a drain is a linear term, never the constant
   `ASSERT_IMPLY(a_last_linear, clock, reset, rsp_valid && rsp_last, rsp_out_index != '0)

endmodule

bind gf2_quadratic_system_partial_eval_top gqspe_checker u_gqspe_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_coef_word (req_coef_word),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_index (rsp_out_index),
   .rsp_out_word  (rsp_out_word),
   .rsp_last      (rsp_last)
);

[dv/gf2_quadratic_system_partial_eval_top_tb.sv]
module gf2_quadratic_system_partial_eval_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VAR_MAX       = gqspe_pkg::MAX_VARS_DEF;
   localparam int FIX_CNT       = gqspe_pkg::FIXED_COUNT_DEF;
   localparam int WORD_W        = gqspe_pkg::WORD_W;
   localparam int IDX_W         = gqspe_pkg::IDX_W;
   localparam int CSR_AW        = gqspe_pkg::CSR_AW;
   localparam int CSR_DW        = gqspe_pkg::CSR_DW;
   localparam int NUM_VARS_W    = gqspe_pkg::NUM_VARS_W;
   localparam int FIX_VAL_W     = gqspe_pkg::FIX_VAL_W;
   localparam int ACC_SLOTS     = VAR_MAX - FIX_CNT + 1;
   localparam int IDLE_PCT      = 31;
   localparam int SETTLE_CYCLES = 120;
   localparam int CYCLE_LIMIT   = 400000;

   // hand-picked words for the first system: extremes and walking patterns
   localparam logic [WORD_W-1:0] EDGE_WORDS [16] = '{
      32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000, 32'hAAAA_AAAA,
      32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000, 32'h0000_0000,
      32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0001, 32'h7FFF_FFFE,
      32'hF0F0_F0F0, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 32'h0000_0000
   };

   typedef struct packed {
      logic [IDX_W-1:0]  index;
      logic [WORD_W-1:0] word;
      logic              last;
   } term_type;

   logic                clock;
   logic                reset;
   logic                csr_psel;
   logic                csr_penable;
   logic                csr_pwrite;
   logic [CSR_AW-1:0]   csr_paddr;
   logic [CSR_DW-1:0]   csr_pwdata;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;
   logic                req_valid;
   logic                req_ready;
   logic [WORD_W-1:0]   req_coef_word;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [IDX_W-1:0]    rsp_out_index;
   logic [WORD_W-1:0]   rsp_out_word;
   logic                rsp_last;

   gf2_quadratic_system_partial_eval_top u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_coef_word (req_coef_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_index (rsp_out_index),
      .rsp_out_word  (rsp_out_word),
      .rsp_last      (rsp_last)
   );

   // predictor state
   logic [NUM_VARS_W-1:0] cfg_num_vars;
   logic [FIX_VAL_W-1:0]  cfg_fixed;
   logic [WORD_W-1:0]     low_acc [ACC_SLOTS];
   int unsigned           row_var;
   int unsigned           col_var;
   logic [IDX_W-1:0]      next_index;
   gqspe_pkg::phase_type  stream_phase;

   logic [WORD_W-1:0] coef_pending [$];
   term_type          expected_terms [$];

   bit quiet;
   int cycle_count;
   int fail_count;
   int words_sent;
   int results_seen;
   int systems_done;
   int settings_used;

   // variable count after clamping
   function automatic int unsigned eff_vars();
      int unsigned n;
      n = cfg_num_vars;
      if (n > VAR_MAX) n = VAR_MAX;
      if (n < FIX_CNT + 1) n = FIX_CNT + 1;
      return n;
   endfunction

   function automatic bit fix_bit(int unsigned k);
      return (k < FIX_CNT) ? cfg_fixed[k] : 1'b0;
   endfunction

   function automatic void restart_system();
      foreach (low_acc[k]) low_acc[k] = '0;
      row_var      = 0;
      col_var      = 0;
      stream_phase = gqspe_pkg::PH_CONST;
      next_index   = IDX_W'(eff_vars() - FIX_CNT + 1);
   endfunction

   // substitute the fixed variables into one coefficient, queue what comes out
   function automatic void fold_coef(logic [WORD_W-1:0] w);
      int unsigned n;
      int unsigned nn;
      term_type    t;
      n  = eff_vars();
      nn = n - FIX_CNT;
      case (stream_phase)
         gqspe_pkg::PH_LIN: begin
            if (row_var < FIX_CNT) begin
               if (fix_bit(row_var)) low_acc[0] ^= w;
            end else if (row_var < VAR_MAX) begin
               low_acc[row_var - FIX_CNT + 1] = w;
            end
            row_var++;
            if (row_var >= n) begin
               stream_phase = gqspe_pkg::PH_QUAD;
               row_var      = 0;
               col_var      = 1;
               next_index   = IDX_W'(nn + 1);
            end
         end
         gqspe_pkg::PH_QUAD: begin
            if (row_var < FIX_CNT) begin
               if (col_var < FIX_CNT) begin
                  if (fix_bit(row_var) && fix_bit(col_var)) low_acc[0] ^= w;
               end else if (fix_bit(row_var) && col_var < VAR_MAX) begin
                  low_acc[col_var - FIX_CNT + 1] ^= w;
               end
            end else begin
               // kept pair goes straight out
               t.index = next_index;
               t.word  = w;
               t.last  = 1'b0;
               expected_terms.push_back(t);
               next_index++;
            end
            col_var++;
            if (col_var >= n) begin
               row_var++;
               col_var = row_var + 1;
               if (col_var >= n) begin
                  // end of system: constant then linear accumulators
                  for (int unsigned k = 0; k <= nn && k < ACC_SLOTS; k++) begin
                     t.index = IDX_W'(k);
                     t.word  = low_acc[k];
                     t.last  = (k == nn);
                     expected_terms.push_back(t);
                  end
                  restart_system();
               end
            end
         end
         default: begin
            low_acc[0]   = w;
            stream_phase = gqspe_pkg::PH_LIN;
            row_var      = 0;
            col_var      = 0;
         end
      endcase
   endfunction

   function automatic logic [WORD_W-1:0] rand_coef();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         2: return WORD_W'(1) << $urandom_range(WORD_W - 1);
         3: return ~(WORD_W'(1) << $urandom_range(WORD_W - 1));
         default: return $urandom;
      endcase
   endfunction

   function automatic void note_error(string msg);
      if (fail_count < 10) $display("ERROR: %s", msg);
      fail_count++;
   endfunction

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("gf2_quadratic_system_partial_eval_top verification failed");
         $finish;
      end
   end

   // coefficient driver
   always @(posedge clock) begin : coef_drive
      bit taken;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         taken = req_valid && req_ready;
         if (taken) begin
            fold_coef(req_coef_word);
            words_sent++;
         end
         if (!req_valid || taken) begin
            if (coef_pending.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
               req_valid     <= 1'b1;
               req_coef_word <= coef_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : term_check
      term_type want;
      rsp_ready <= !reset && (quiet || $urandom_range(99) >= IDLE_PCT);
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_terms.size() == 0) begin
            note_error($sformatf("unexpected result index %0d word %h last %b",
                                 rsp_out_index, rsp_out_word, rsp_last));
         end else begin
            want = expected_terms.pop_front();
            if (rsp_out_index !== want.index || rsp_out_word !== want.word ||
                rsp_last !== want.last) begin
               note_error($sformatf("exp index %0d word %h last %b, got %0d %h %b",
                                    want.index, want.word, want.last,
                                    rsp_out_index, rsp_out_word, rsp_last));
            end
            if (want.last) systems_done++;
         end
      end
   end

   // one register write: setup, then access
   task automatic csr_write(input gqspe_pkg::reg_idx_type r, input logic [CSR_DW-1:0] d);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= d;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (r)
         gqspe_pkg::REG_NUM_VARS:     cfg_num_vars = d[NUM_VARS_W-1:0];
         gqspe_pkg::REG_FIXED_VALUES: cfg_fixed    = d[FIX_VAL_W-1:0];
         default: ;
      endcase
      restart_system();
      settings_used++;
   endtask

   // wait for all traffic to finish, then let the back end go quiet
   task automatic settle();
      do @(negedge clock);
      while (coef_pending.size() != 0 || req_valid || expected_terms.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_system();
      int unsigned n;
      n = eff_vars();
      repeat (1 + n + n * (n - 1) / 2) coef_pending.push_back(rand_coef());
   endtask

   // a phase: new setting, some full systems, maybe a cut-off one
   task automatic run_phase(input logic [CSR_DW-1:0] nv, input logic [CSR_DW-1:0] fv,
                            input int systems, input int partial, input bit calm);
      csr_write(gqspe_pkg::REG_NUM_VARS, nv);
      csr_write(gqspe_pkg::REG_FIXED_VALUES, fv);
      quiet = calm;
      repeat (systems) push_system();
      repeat (partial) coef_pending.push_back(rand_coef());
      settle();
   endtask

   initial begin
      reset         = 1'b1;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      req_valid     = 1'b0;
      req_coef_word = '0;
      rsp_ready     = 1'b0;
      quiet         = 1'b0;
      cfg_num_vars  = gqspe_pkg::NUM_VARS_RST;
      cfg_fixed     = '0;
      restart_system();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // smallest system, all fixed variables set, then a system cut off by a write
      csr_write(gqspe_pkg::REG_NUM_VARS, 32'd5);
      csr_write(gqspe_pkg::REG_FIXED_VALUES, 32'hF);
      foreach (EDGE_WORDS[d]) coef_pending.push_back(EDGE_WORDS[d]);
      repeat (6) coef_pending.push_back(rand_coef());
      settle();

      // random systems over several settings, clamped counts included
      run_phase(32'd0, 32'hFFFF_FFF5, 2, 0, 1'b0);
      run_phase(32'h0000_0047, 32'hA, 2, 0, 1'b1);
      run_phase(32'd63, 32'h3, 0, 20, 1'b0);
      run_phase(32'd6, 32'h0, 2, 5, 1'b0);
      run_phase(32'd8, 32'h9, 1, 5, 1'b0);
      run_phase(32'd4, 32'hC, 2, 0, 1'b0);

      $display("covered %0d coefficient words and %0d reduced systems, %0d results checked",
               words_sent, systems_done, results_seen);
      $display("%0d register writes, counts 5 to 8 plus clamped and cut-off, %0d mismatches",
               settings_used, fail_count);
      if (fail_count == 0) begin
         $display("gf2_quadratic_system_partial_eval_top verification clean");
      end else begin
         $display("gf2_quadratic_system_partial_eval_top verification failed");
      end
      $finish;
   end

endmodule
